[rtl/diff_drive_wheel_mixer_assert.svh]
// assertion macros used by the wheel mixer checker
`ifndef DIFF_DRIVE_WHEEL_MIXER_ASSERT_SVH
`define DIFF_DRIVE_WHEEL_MIXER_ASSERT_SVH

// checked only out of reset
`define DDWM_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define DDWM_CHECK_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/ddwm_pkg.sv]
// types and constants of the differential drive wheel mixer
package ddwm_pkg;

    localparam int SPEED_W   = 16;
    localparam int TRACK_W   = 16;
    localparam int MAX_W     = 15;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TRACK_WIDTH     = 2'd0,
        CFG_MAX_WHEEL_SPEED = 2'd1
    } cfg_index_t;

    typedef struct packed {
        logic signed [SPEED_W-1:0] linear_speed;
        logic signed [SPEED_W-1:0] angular_rate;
    } cmd_t;

    typedef struct packed {
        logic signed [SPEED_W-1:0] left_speed;
        logic signed [SPEED_W-1:0] right_speed;
        logic                      was_scaled;
    } wheel_t;

    typedef struct packed {
        logic               sign_l;
        logic               sign_r;
        logic               scaled;
        logic [SPEED_W-1:0] base_l;
        logic [SPEED_W-1:0] base_r;
    } side_t;

endpackage

[rtl/diff_drive_wheel_mixer.sv]
// differential drive wheel mixer: body command to limited wheel speeds
// path from an accepted command word to its wheel word:
// three front stages, one divider stage per bit of the speed limit, output register
// throughput: one word per cycle while the output is not stalled; pipeline bubbles are squeezed out under output stall
// reset: pipeline valid bits clear, track width and speed limit registers read 0
module diff_drive_wheel_mixer
    import ddwm_pkg::*;
#(
    parameter int FRAC_BITS = 10
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    output logic                 cmd_stall,
    input  cmd_t                 cmd,
    output logic                 wheel_valid,
    input  logic                 wheel_stall,
    output wheel_t               wheel,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int UNIT_SH = FRAC_BITS + 1;
    localparam int PROD_W  = SPEED_W + TRACK_W + 1;
    localparam int LIN_W   = SPEED_W + UNIT_SH;
    localparam int EXT_W   = ((PROD_W > LIN_W) ? PROD_W : LIN_W) + 1;
    localparam int NUM_W   = EXT_W + MAX_W;

    logic [TRACK_W-1:0] track_reg;
    logic [MAX_W-1:0]   max_reg;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            track_reg <= '0;
            max_reg   <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_TRACK_WIDTH:     track_reg <= cfg_data[TRACK_W-1:0];
                CFG_MAX_WHEEL_SPEED: max_reg   <= cfg_data[MAX_W-1:0];
                default:             ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    logic                    s1_valid_reg;
    logic signed [EXT_W-1:0] s1_diff_reg;
    logic signed [EXT_W-1:0] s1_lin_reg;
    logic                    s2_valid_reg;
    logic [EXT_W-1:0]        s2_mag_l_reg;
    logic [EXT_W-1:0]        s2_mag_r_reg;
    logic                    s2_sign_l_reg;
    logic                    s2_sign_r_reg;
    logic                    s3_valid_reg;
    logic [NUM_W-1:0]        s3_num_l_reg;
    logic [NUM_W-1:0]        s3_num_r_reg;
    logic [EXT_W-1:0]        s3_peak_reg;
    side_t                   s3_side_reg;
    logic                    wheel_valid_reg;
    wheel_t                  wheel_reg;

    logic s1_en;
    logic s2_en;
    logic s3_en;
    logic out_en;
    logic div_in_ready;
    logic div_out_valid;

    assign out_en    = !wheel_valid_reg || !wheel_stall;
    assign s3_en     = !s3_valid_reg || div_in_ready;
    assign s2_en     = !s2_valid_reg || s3_en;
    assign s1_en     = !s1_valid_reg || s2_en;
    assign cmd_stall = !s1_en;

    // stage 1: differential and scaled linear term
    logic signed [EXT_W-1:0] ang_x;
    logic signed [EXT_W-1:0] trk_x;
    logic signed [EXT_W-1:0] diff_next;
    logic signed [EXT_W-1:0] lin_next;

    assign ang_x     = EXT_W'(cmd.angular_rate);
    assign trk_x     = signed'(EXT_W'(track_reg));
    assign diff_next = ang_x * trk_x;
    assign lin_next  = EXT_W'(cmd.linear_speed) <<< UNIT_SH;

    // stage 2: wheel terms as sign and magnitude
    logic signed [EXT_W-1:0] ext_l;
    logic signed [EXT_W-1:0] ext_r;
    logic [EXT_W-1:0]        mag_l_next;
    logic [EXT_W-1:0]        mag_r_next;

    assign ext_l      = s1_lin_reg - s1_diff_reg;
    assign ext_r      = s1_lin_reg + s1_diff_reg;
    assign mag_l_next = ext_l[EXT_W-1] ? -ext_l : ext_l;
    assign mag_r_next = ext_r[EXT_W-1] ? -ext_r : ext_r;

    // stage 3: peak against limit, numerators for the divider
    logic [EXT_W-1:0] peak_next;
    logic [EXT_W-1:0] lim_ext;
    side_t            side_next;

    assign peak_next = (s2_mag_l_reg > s2_mag_r_reg) ? s2_mag_l_reg : s2_mag_r_reg;
    assign lim_ext   = EXT_W'(max_reg) << UNIT_SH;

    always_comb
    begin
        side_next.sign_l = s2_sign_l_reg;
        side_next.sign_r = s2_sign_r_reg;
        side_next.scaled = peak_next > lim_ext;
        side_next.base_l = SPEED_W'(s2_mag_l_reg >> UNIT_SH);
        side_next.base_r = SPEED_W'(s2_mag_r_reg >> UNIT_SH);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            s2_valid_reg    <= 1'b0;
            s3_valid_reg    <= 1'b0;
            wheel_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_en)
            begin
                s1_valid_reg <= cmd_valid;
            end
            if (s2_en)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_en)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (out_en)
            begin
                wheel_valid_reg <= div_out_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_en && cmd_valid)
        begin
            s1_diff_reg <= diff_next;
            s1_lin_reg  <= lin_next;
        end
        if (s2_en && s1_valid_reg)
        begin
            s2_mag_l_reg  <= mag_l_next;
            s2_mag_r_reg  <= mag_r_next;
            s2_sign_l_reg <= ext_l[EXT_W-1];
            s2_sign_r_reg <= ext_r[EXT_W-1];
        end
        if (s3_en && s2_valid_reg)
        begin
            s3_num_l_reg <= NUM_W'(s2_mag_l_reg) * NUM_W'(max_reg);
            s3_num_r_reg <= NUM_W'(s2_mag_r_reg) * NUM_W'(max_reg);
            s3_peak_reg  <= peak_next;
            s3_side_reg  <= side_next;
        end
    end

    logic [MAX_W-1:0] q_l;
    logic [MAX_W-1:0] q_r;
    side_t            div_side;

    ddwm_div #(
        .NUM_W (NUM_W),
        .DEN_W (EXT_W),
        .Q_W   (MAX_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s3_valid_reg),
        .in_ready  (div_in_ready),
        .in_num_l  (s3_num_l_reg),
        .in_num_r  (s3_num_r_reg),
        .in_den    (s3_peak_reg),
        .in_side   (s3_side_reg),
        .out_valid (div_out_valid),
        .out_ready (out_en),
        .out_q_l   (q_l),
        .out_q_r   (q_r),
        .out_side  (div_side)
    );

    // output: pick scaled or plain magnitude, restore the sign
    logic [SPEED_W-1:0] sel_l;
    logic [SPEED_W-1:0] sel_r;
    wheel_t             wheel_next;

    assign sel_l = div_side.scaled ? SPEED_W'(q_l) : div_side.base_l;
    assign sel_r = div_side.scaled ? SPEED_W'(q_r) : div_side.base_r;

    always_comb
    begin
        wheel_next.left_speed  = div_side.sign_l ? -sel_l : sel_l;
        wheel_next.right_speed = div_side.sign_r ? -sel_r : sel_r;
        wheel_next.was_scaled  = div_side.scaled;
    end

    always_ff @(posedge clk)
    begin
        if (out_en && div_out_valid)
        begin
            wheel_reg <= wheel_next;
        end
    end

    assign wheel_valid = wheel_valid_reg;
    assign wheel       = wheel_reg;

endmodule

[rtl/ddwm_div.sv]
// pipelined two-lane restoring divider, one quotient bit per stage
module ddwm_div
    import ddwm_pkg::*;
#(
    parameter int NUM_W = 49,
    parameter int DEN_W = 34,
    parameter int Q_W   = 15
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [NUM_W-1:0] in_num_l,
    input  logic [NUM_W-1:0] in_num_r,
    input  logic [DEN_W-1:0] in_den,
    input  side_t            in_side,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [Q_W-1:0]   out_q_l,
    output logic [Q_W-1:0]   out_q_r,
    output side_t            out_side
);

    logic             v_reg   [Q_W];
    logic [NUM_W-1:0] nl_reg  [Q_W];
    logic [NUM_W-1:0] nr_reg  [Q_W];
    logic [DEN_W-1:0] den_reg [Q_W];
    logic [Q_W-1:0]   ql_reg  [Q_W];
    logic [Q_W-1:0]   qr_reg  [Q_W];
    side_t            side_reg[Q_W];

    logic             v_src   [Q_W];
    logic [NUM_W-1:0] nl_src  [Q_W];
    logic [NUM_W-1:0] nr_src  [Q_W];
    logic [DEN_W-1:0] den_src [Q_W];
    logic [Q_W-1:0]   ql_src  [Q_W];
    logic [Q_W-1:0]   qr_src  [Q_W];
    side_t            side_src[Q_W];

    logic [NUM_W-1:0] nl_next [Q_W];
    logic [NUM_W-1:0] nr_next [Q_W];
    logic [Q_W-1:0]   ql_next [Q_W];
    logic [Q_W-1:0]   qr_next [Q_W];

    logic [Q_W:0]     en_chain;

    // a stage moves when it is empty or the one after it moves
    always_comb
    begin
        en_chain[Q_W] = out_ready;
        for (int k = Q_W - 1; k >= 0; k--)
        begin
            en_chain[k] = !v_reg[k] || en_chain[k+1];
        end
    end

    always_comb
    begin
        v_src[0]    = in_valid;
        nl_src[0]   = in_num_l;
        nr_src[0]   = in_num_r;
        den_src[0]  = in_den;
        ql_src[0]   = '0;
        qr_src[0]   = '0;
        side_src[0] = in_side;
        for (int k = 1; k < Q_W; k++)
        begin
            v_src[k]    = v_reg[k-1];
            nl_src[k]   = nl_reg[k-1];
            nr_src[k]   = nr_reg[k-1];
            den_src[k]  = den_reg[k-1];
            ql_src[k]   = ql_reg[k-1];
            qr_src[k]   = qr_reg[k-1];
            side_src[k] = side_reg[k-1];
        end
    end

    // stage k settles quotient bit Q_W-1-k against the shifted divisor
    always_comb
    begin
        logic [NUM_W:0] dsh;
        logic           bit_l;
        logic           bit_r;
        for (int k = 0; k < Q_W; k++)
        begin
            dsh        = (NUM_W + 1)'(den_src[k]) << (Q_W - 1 - k);
            bit_l      = {1'b0, nl_src[k]} >= dsh;
            bit_r      = {1'b0, nr_src[k]} >= dsh;
            nl_next[k] = bit_l ? nl_src[k] - dsh[NUM_W-1:0] : nl_src[k];
            nr_next[k] = bit_r ? nr_src[k] - dsh[NUM_W-1:0] : nr_src[k];
            ql_next[k] = {ql_src[k][Q_W-2:0], bit_l};
            qr_next[k] = {qr_src[k][Q_W-2:0], bit_r};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < Q_W; k++)
            begin
                v_reg[k] <= 1'b0;
            end
        end
        else
        begin
            for (int k = 0; k < Q_W; k++)
            begin
                if (en_chain[k])
                begin
                    v_reg[k] <= v_src[k];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < Q_W; k++)
        begin
            if (en_chain[k] && v_src[k])
            begin
                nl_reg[k]   <= nl_next[k];
                nr_reg[k]   <= nr_next[k];
                den_reg[k]  <= den_src[k];
                ql_reg[k]   <= ql_next[k];
                qr_reg[k]   <= qr_next[k];
                side_reg[k] <= side_src[k];
            end
        end
    end

    assign in_ready  = en_chain[0];
    assign out_valid = v_reg[Q_W-1];
    assign out_q_l   = ql_reg[Q_W-1];
    assign out_q_r   = qr_reg[Q_W-1];
    assign out_side  = side_reg[Q_W-1];

endmodule

[rtl/ddwm_checker.sv]
// port checker for the wheel mixer and its bind
`include "diff_drive_wheel_mixer_assert.svh"

module ddwm_checker
    import ddwm_pkg::*;
(
    input logic   clk,
    input logic   rst_n,
    input logic   cmd_stall,
    input logic   wheel_valid,
    input logic   wheel_stall,
    input wheel_t wheel
);

    localparam logic signed [SPEED_W-1:0] SPEED_MIN = {1'b1, {(SPEED_W-1){1'b0}}};

    logic held;
    logic speeds_ok;

    assign held      = wheel_valid && wheel_stall;
    assign speeds_ok = (wheel.left_speed != SPEED_MIN) && (wheel.right_speed != SPEED_MIN);

    // no word comes out right after reset
    `DDWM_CHECK_ALWAYS(a_idle_after_reset, !rst_n |=> !wheel_valid, "word after reset")

    // input only backs up when the output word is held
    `DDWM_CHECK(a_stall_from_output, cmd_stall |-> held, "needless input stall")

    // wheel magnitudes never reach the most negative code
    `DDWM_CHECK(a_speed_range, wheel_valid |-> speeds_ok, "wheel speed out of range")

    // held output word stays put
    `DDWM_CHECK(a_hold, held |=> (wheel_valid && $stable(wheel)), "held word changed")

endmodule

bind diff_drive_wheel_mixer ddwm_checker u_ddwm_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_stall   (cmd_stall),
    .wheel_valid (wheel_valid),
    .wheel_stall (wheel_stall),
    .wheel       (wheel)
);
